// ===== hw/rtl/pressure_temperature_compensation_assert.svh =====
// Assertion macros for the compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// Same-cycle implication, sampled on the block clock.
`define PTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");

// Next-cycle implication, sampled on the block clock.
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");

`endif

// ===== hw/rtl/ptc_pkg.sv =====
// Shared types, constants and helpers for the compensation block.
package ptc_pkg;
    localparam int unsigned SerialBits = 64;
    localparam int unsigned CountBits  = 6;

    localparam logic [1:0] RegTemp    = 2'd0;
    localparam logic [1:0] RegPressLo = 2'd1;
    localparam logic [1:0] RegPressHi = 2'd2;
    localparam logic [1:0] RegPressP9 = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction
endpackage

// ===== hw/rtl/ptc_mul.sv =====
// Bit-serial 64-bit multiplier, low 64 bits of the product.
module ptc_mul
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_unit_stat  o_stat,
    output logic [63:0] o_prod
);
    logic [63:0]          r_a;
    logic [63:0]          r_b;
    logic [63:0]          r_acc;
    logic [CountBits-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[62:0], 1'b0};
                r_b   <= {1'b0, r_b[63:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CountBits'(SerialBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_prod = r_acc;
endmodule

// ===== hw/rtl/ptc_div.sv =====
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module ptc_div
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output t_unit_stat  o_stat,
    output logic [63:0] o_quot
);
    logic [63:0]          r_q;
    logic [63:0]          r_rem;
    logic [63:0]          r_d;
    logic [CountBits-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [64:0]          w_sh;
    logic [64:0]          w_diff;

    assign w_sh   = {r_rem, r_q[63]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_d    <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CountBits'(SerialBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// Top level: integer temperature and 64-bit pressure compensation sequencer.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata raw_sample, tuser mode
//  m_axis   | out       | tdata temperature/pressure, tuser is_pressure/zero_divisor
//  cfg      | in        | register index and 64-bit write data
//
// A temperature transaction runs four serial multiplies. A pressure transaction
// runs ten serial multiplies and one serial divide; a zero divisor skips the
// divide and the tail.
// Reset is synchronous and clears control state, coefficients and fine temperature.
// A new input transaction is taken while the previous result waits on m_axis.
`include "pressure_temperature_compensation_assert.svh"
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [19:0] raw_sample, rest zero
    input  logic        i_s_tuser,   // [0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] temperature_centideg, [63:32] pressure_pa
    output logic [1:0]  o_m_tuser,   // [0] is_pressure, [1] zero_divisor
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
        S_P8, S_P9, S_P10, S_P11, S_P12, S_P13,
        S_MWAIT, S_DWAIT
    } t_state;

    t_state      r_state;
    t_state      r_next;
    logic [47:0] r_tc;
    logic [63:0] r_pl;
    logic [63:0] r_ph;
    logic [15:0] r_p9;
    logic [31:0] r_fine;
    logic [19:0] r_adc;
    logic [63:0] r_v1;
    logic [63:0] r_v2;
    logic [63:0] r_s;
    logic [63:0] r_acc;
    logic [63:0] r_d;
    logic [63:0] r_p;
    logic        r_zero;
    logic        r_neg;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_user;
    logic        r_mstart;
    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic        r_dstart;
    logic [63:0] r_dn;
    logic [63:0] r_dd;

    t_unit_stat  w_mstat;
    t_unit_stat  w_dstat;
    logic [63:0] w_prod;
    logic [63:0] w_quot;
    logic [63:0] w_p32;
    logic [31:0] w_ta;
    logic [31:0] w_td;
    logic [31:0] w_fine_new;
    logic [63:0] w_sh14;
    logic [31:0] w_tsum;
    logic [31:0] w_temp;
    logic [63:0] w_v1;
    logic [63:0] w_num;
    logic [63:0] w_dq;
    logic [63:0] w_pr;
    logic [63:0] w_pq;
    logic [63:0] w_pabs;
    logic        w_out_free;

    ptc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_stat  (w_mstat),
        .o_prod  (w_prod)
    );

    ptc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dn),
        .i_divisor  (r_dd),
        .o_stat     (w_dstat),
        .o_quot     (w_quot)
    );

    assign w_p32      = {{32{w_prod[31]}}, w_prod[31:0]};
    assign w_ta       = {15'd0, r_adc[19:3]} - {15'd0, r_tc[15:0], 1'b0};
    assign w_td       = {16'd0, r_adc[19:4]} - {16'd0, r_tc[15:0]};
    assign w_sh14     = $signed(w_p32) >>> 14;
    assign w_fine_new = r_v1[31:0] + w_sh14[31:0];
    assign w_tsum     = w_prod[31:0] + 32'd128;
    assign w_temp     = $signed(w_tsum) >>> 8;
    assign w_v1       = {{32{r_fine[31]}}, r_fine} - 64'd128000;
    assign w_num      = ((64'd1048576 - {44'd0, r_adc}) << 31) - r_v2;
    assign w_dq       = $signed(w_prod) >>> 33;
    assign w_pr       = $signed(r_p) >>> 13;
    assign w_pq       = r_acc + (r_acc[63] ? 64'd255 : 64'd0);
    assign w_pabs     = $signed(w_pq) >>> 8;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= S_IDLE;
            r_tc        <= '0;
            r_pl        <= '0;
            r_ph        <= '0;
            r_p9        <= '0;
            r_fine      <= '0;
            r_out_valid <= 1'b0;
            r_mstart    <= 1'b0;
            r_dstart    <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegTemp:    r_tc <= i_cfg_data[47:0];
                    RegPressLo: r_pl <= i_cfg_data;
                    RegPressHi: r_ph <= i_cfg_data;
                    RegPressP9: r_p9 <= i_cfg_data[15:0];
                    default:    ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_adc   <= i_s_tdata[19:0];
                        r_state <= i_s_tuser ? S_P0 : S_T0;
                    end
                end
                S_T0: begin
                    r_d <= {{32{w_td[31]}}, w_td};
                    r_ma <= {{32{w_ta[31]}}, w_ta}; r_mb <= sx16(r_tc[31:16]);
                    r_mstart <= 1'b1; r_next <= S_T1; r_state <= S_MWAIT;
                end
                S_T1: begin
                    r_v1 <= $signed(w_p32) >>> 11;
                    r_ma <= r_d; r_mb <= r_d;
                    r_mstart <= 1'b1; r_next <= S_T2; r_state <= S_MWAIT;
                end
                S_T2: begin
                    r_ma <= $signed(w_p32) >>> 12; r_mb <= sx16(r_tc[47:32]);
                    r_mstart <= 1'b1; r_next <= S_T3; r_state <= S_MWAIT;
                end
                S_T3: begin
                    r_fine <= w_fine_new;
                    r_ma <= {{32{w_fine_new[31]}}, w_fine_new}; r_mb <= 64'd5;
                    r_mstart <= 1'b1; r_next <= S_T4; r_state <= S_MWAIT;
                end
                S_T4: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {32'd0, w_temp};
                        r_out_user  <= 2'b00;
                        r_state     <= S_IDLE;
                    end
                end
                S_P0: begin
                    r_v1 <= w_v1;
                    r_ma <= w_v1; r_mb <= w_v1;
                    r_mstart <= 1'b1; r_next <= S_P1; r_state <= S_MWAIT;
                end
                S_P1: begin
                    r_s <= w_prod;
                    r_ma <= w_prod; r_mb <= sx16(r_ph[31:16]);
                    r_mstart <= 1'b1; r_next <= S_P2; r_state <= S_MWAIT;
                end
                S_P2: begin
                    r_v2 <= w_prod;
                    r_ma <= r_v1; r_mb <= sx16(r_ph[15:0]);
                    r_mstart <= 1'b1; r_next <= S_P3; r_state <= S_MWAIT;
                end
                S_P3: begin
                    r_v2 <= r_v2 + (w_prod << 17) +
                            {{13{r_pl[63]}}, r_pl[63:48], 35'd0};
                    r_ma <= r_s; r_mb <= sx16(r_pl[47:32]);
                    r_mstart <= 1'b1; r_next <= S_P4; r_state <= S_MWAIT;
                end
                S_P4: begin
                    r_acc <= $signed(w_prod) >>> 8;
                    r_ma <= r_v1; r_mb <= sx16(r_pl[31:16]);
                    r_mstart <= 1'b1; r_next <= S_P5; r_state <= S_MWAIT;
                end
                S_P5: begin
                    r_ma <= 64'h0000_8000_0000_0000 + r_acc + (w_prod << 12);
                    r_mb <= {48'd0, r_pl[15:0]};
                    r_mstart <= 1'b1; r_next <= S_P6; r_state <= S_MWAIT;
                end
                S_P6: begin
                    r_d    <= w_dq;
                    r_zero <= (w_dq == 64'd0);
                    r_ma <= w_num; r_mb <= 64'd3125;
                    r_mstart <= 1'b1; r_next <= S_P7; r_state <= S_MWAIT;
                end
                S_P7: begin
                    if (r_zero) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= 64'd0;
                            r_out_user  <= 2'b11;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_neg    <= w_prod[63] ^ r_d[63];
                        r_dn     <= w_prod[63] ? -w_prod : w_prod;
                        r_dd     <= r_d[63] ? -r_d : r_d;
                        r_dstart <= 1'b1;
                        r_state  <= S_DWAIT;
                    end
                end
                S_P8: begin
                    r_ma <= w_pr; r_mb <= w_pr;
                    r_mstart <= 1'b1; r_next <= S_P9; r_state <= S_MWAIT;
                end
                S_P9: begin
                    r_ma <= w_prod; r_mb <= sx16(r_p9);
                    r_mstart <= 1'b1; r_next <= S_P10; r_state <= S_MWAIT;
                end
                S_P10: begin
                    r_acc <= $signed(w_prod) >>> 25;
                    r_ma <= r_p; r_mb <= sx16(r_ph[63:48]);
                    r_mstart <= 1'b1; r_next <= S_P11; r_state <= S_MWAIT;
                end
                S_P11: begin
                    r_acc   <= r_p + r_acc + 64'($signed(w_prod) >>> 19);
                    r_state <= S_P12;
                end
                S_P12: begin
                    r_acc   <= 64'($signed(r_acc) >>> 8) +
                               {{44{r_ph[47]}}, r_ph[47:32], 4'd0};
                    r_state <= S_P13;
                end
                S_P13: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {w_pabs[31:0], 32'd0};
                        r_out_user  <= 2'b01;
                        r_state     <= S_IDLE;
                    end
                end
                S_MWAIT: begin
                    if (w_mstat.done) begin
                        r_state <= r_next;
                    end
                end
                S_DWAIT: begin
                    if (w_dstat.done) begin
                        r_p     <= r_neg ? -w_quot : w_quot;
                        r_state <= S_P8;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;
    assign o_cfg_ready = 1'b1;

    `PTC_ASSERT_NEXT(a_accept_leaves_idle, i_s_tvalid && o_s_tready, r_state != S_IDLE)
    `PTC_ASSERT_NOW(a_mwait_unit_active, r_state == S_MWAIT && !r_mstart,
                    w_mstat.busy || w_mstat.done)
    `PTC_ASSERT_NOW(a_dwait_unit_active, r_state == S_DWAIT && !r_dstart,
                    w_dstat.busy || w_dstat.done)
    `PTC_ASSERT_NOW(a_zero_flag_only_pressure, o_m_tvalid && o_m_tuser[1],
                    o_m_tuser[0] && o_m_tdata == 64'd0)
endmodule
